[sv/iia_pkg.sv]
package iia_pkg;

    localparam int DEPTH   = 64;
    localparam int WORD_W  = 32;
    localparam int POS_W   = 7;
    localparam int FUNC_W  = 2;
    localparam int STAT_W  = 2;
    localparam int GROUP   = 8;
    localparam int NGRP    = (DEPTH + GROUP - 1) / GROUP;

    localparam logic [FUNC_W-1:0] OP_APPEND = 2'd0;
    localparam logic [FUNC_W-1:0] OP_INSERT = 2'd1;
    localparam logic [FUNC_W-1:0] OP_EDIT   = 2'd2;
    localparam logic [FUNC_W-1:0] OP_GET    = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_BADIDX = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;

    typedef struct packed {
        logic              active;
        logic              insert_en;
        logic              write_en;
        logic              read_en;
        logic [POS_W-1:0]  tgt;
        logic [WORD_W-1:0] word;
    } cell_cmd_t;

endpackage

[sv/iia_cell.sv]
module iia_cell
(
    input  logic                         clk,
    input  iia_pkg::cell_cmd_t           cmd,
    input  logic [iia_pkg::POS_W-1:0]    idx,
    input  logic [iia_pkg::WORD_W-1:0]   left_word,
    output logic [iia_pkg::WORD_W-1:0]   word,
    output logic [iia_pkg::WORD_W-1:0]   tap
);
    import iia_pkg::*;

    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] word_next;
    logic [WORD_W-1:0] tap_reg;
    logic [WORD_W-1:0] tap_next;
    logic              hit;

    assign hit = (idx == cmd.tgt);

    always_comb
    begin
        word_next = word_reg;
        tap_next  = tap_reg;
        if (cmd.active)
        begin
            if (cmd.insert_en && (idx > cmd.tgt))
            begin
                word_next = left_word;
            end
            else if ((cmd.insert_en || cmd.write_en) && hit)
            begin
                word_next = cmd.word;
            end
            tap_next = (cmd.read_en && hit) ? word_reg : '0;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        tap_reg  <= tap_next;
    end

    assign word = word_reg;
    assign tap  = tap_reg;

endmodule

[sv/iia_or_tree.sv]
module iia_or_tree
(
    input  logic                         clk,
    input  logic [iia_pkg::WORD_W-1:0]   taps [iia_pkg::DEPTH],
    output logic [iia_pkg::WORD_W-1:0]   result
);
    import iia_pkg::*;

    logic [WORD_W-1:0] grp_reg  [NGRP];
    logic [WORD_W-1:0] grp_next [NGRP];

    always_comb
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            grp_next[g] = '0;
            for (int k = 0; k < GROUP; k++)
            begin
                if (g * GROUP + k < DEPTH)
                begin
                    grp_next[g] = grp_next[g] | taps[g * GROUP + k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int g = 0; g < NGRP; g++)
        begin
            grp_reg[g] <= grp_next[g];
        end
    end

    always_comb
    begin
        result = '0;
        for (int g = 0; g < NGRP; g++)
        begin
            result = result | grp_reg[g];
        end
    end

endmodule

[sv/indexed_insert_array_unit.sv]
// Indexed insert array: an ordered row of signed 32-bit words with a fill count.
// The input channel (in_valid, in_ready) carries one word holding func, position
// and word_in: append, insert at position, edit at position or get at position.
// The output channel (out_valid, out_ready) returns one word per input word:
// word_out (the element read by a successful get, otherwise zero), status
// (ok, invalid index or full) and fill, the count after the operation.
// Each element sits in a cell of a chain; insert moves every element at or
// above the position one place up at once, and the cells record a read tap.
// A get is collected by an OR tree with one registered level of groups of eight.
// An item passes through accept, group reduction and final reduction, and
// out_valid rises when the final reduction is loaded into the output register.
// A new word is accepted only once the previous result has been loaded.
// When the receiver stalls, the result waits in the output register; one more
// word may be accepted and then waits in the final stage until it drains.
// Reset empties the array (fill count zero) and clears both channels; stored
// words are undefined until written.
module indexed_insert_array_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [iia_pkg::FUNC_W-1:0]    func,
    input  logic [iia_pkg::POS_W-1:0]     position,
    input  logic signed [iia_pkg::WORD_W-1:0] word_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [iia_pkg::WORD_W-1:0] word_out,
    output logic [iia_pkg::STAT_W-1:0]    status,
    output logic [iia_pkg::POS_W-1:0]     fill
);
    import iia_pkg::*;

    typedef enum logic [2:0]
    {
        S_IDLE  = 3'b001,
        S_GROUP = 3'b010,
        S_FINAL = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [POS_W-1:0]  count_reg, count_next;
    logic [STAT_W-1:0] stat_reg, stat_next;
    logic              out_valid_reg, out_valid_next;
    logic [WORD_W-1:0] word_out_reg;
    logic [STAT_W-1:0] status_reg;
    logic [POS_W-1:0]  fill_reg;

    logic              accept;
    logic              full;
    logic              ok;
    logic              load_out;
    logic [STAT_W-1:0] st;
    cell_cmd_t         cmd;
    logic [WORD_W-1:0] words [DEPTH];
    logic [WORD_W-1:0] taps  [DEPTH];
    logic [WORD_W-1:0] rd_word;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign full     = (count_reg >= POS_W'(DEPTH));

    always_comb
    begin
        unique case (func)
            OP_APPEND: st = full ? ST_FULL : ST_OK;
            OP_INSERT: st = (position > count_reg) ? ST_BADIDX : (full ? ST_FULL : ST_OK);
            default:   st = (position >= count_reg) ? ST_BADIDX : ST_OK;
        endcase
    end

    assign ok = (st == ST_OK);

    always_comb
    begin
        cmd.active    = accept;
        cmd.insert_en = ok && (func == OP_INSERT);
        cmd.write_en  = ok && ((func == OP_APPEND) || (func == OP_EDIT));
        cmd.read_en   = ok && (func == OP_GET);
        cmd.tgt       = (func == OP_APPEND) ? count_reg : position;
        cmd.word      = word_in;
    end

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            logic [WORD_W-1:0] left;
            if (i == 0)
            begin : g_first
                assign left = '0;
            end
            else
            begin : g_rest
                assign left = words[i-1];
            end
            iia_cell u_cell
            (
                .clk       (clk),
                .cmd       (cmd),
                .idx       (POS_W'(i)),
                .left_word (left),
                .word      (words[i]),
                .tap       (taps[i])
            );
        end
    endgenerate

    iia_or_tree u_tree
    (
        .clk    (clk),
        .taps   (taps),
        .result (rd_word)
    );

    assign load_out = (state_reg == S_FINAL) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        stat_next      = stat_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    stat_next  = st;
                    state_next = S_GROUP;
                    if (ok && ((func == OP_APPEND) || (func == OP_INSERT)))
                    begin
                        count_next = count_reg + POS_W'(1);
                    end
                end
            end
            S_GROUP:
            begin
                state_next = S_FINAL;
            end
            S_FINAL:
            begin
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            stat_reg      <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            stat_reg      <= stat_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            word_out_reg <= rd_word;
            status_reg   <= stat_reg;
            fill_reg     <= count_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign word_out  = word_out_reg;
    assign status    = status_reg;
    assign fill      = fill_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= POS_W'(DEPTH))
        else $error("fill count beyond capacity");

    a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_GROUP))
        else $error("accepted word did not enter group reduction");

    a_full_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_FULL)) |-> (fill == POS_W'(DEPTH)))
        else $error("full status with array not full");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != ST_OK)) |-> (word_out == '0))
        else $error("error result carries a nonzero word");

endmodule
